[rtl/mwo_pkg.sv]
package mwo_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;

  // 44100 Hz sample rate with 8 fraction bits
  localparam logic [23:0] RATE_SCALED  = 24'd11289600;
  localparam logic [22:0] FREQ_MAX     = 23'd5644800;
  localparam logic [22:0] FREQ_RESET   = 23'd112640;
  localparam logic [23:0] PERIOD_RESET = 24'd100;
  localparam logic [15:0] LEVEL_FULL   = 16'd32768;
  localparam logic [14:0] AMP_MAX      = 15'd32767;
  localparam logic [14:0] PEAK_RESET   = 15'd32767;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 23;
  localparam int INDEX_W     = 31;
  localparam int SAMPLE_W    = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SHAPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQ  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL = 2'd2;

  // quarter-wave sine polynomial in Q30
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint SIN_C0  = 64'sd1686629713;
  localparam longint SIN_C1  = -64'sd693598668;
  localparam longint SIN_C2  = 64'sd85569306;
  localparam longint SIN_C3  = -64'sd5026995;
  localparam longint SIN_C4  = 64'sd172272;

  typedef enum logic [1:0] {
    SHAPE_SINE,
    SHAPE_SQUARE,
    SHAPE_SAW,
    SHAPE_TRI
  } shape_e;

  typedef struct packed {
    shape_e      shape;
    logic [22:0] freq;
    logic [23:0] period;
    logic [14:0] peak;
  } cfg_t;

  typedef struct packed {
    shape_e             shape;
    logic [INDEX_W-1:0] idx;
  } item_t;

endpackage

[rtl/mwo_queue.sv]
module mwo_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

[rtl/mwo_cfg.sv]
module mwo_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             busy_o,
  output mwo_pkg::cfg_t                    cfg_o
);

  localparam int DivSteps = 24;

  mwo_pkg::shape_e shape_q;
  logic [22:0]     freq_q;
  logic [23:0]     period_q;
  logic [14:0]     peak_q;
  logic            busy_q;
  logic [4:0]      cnt_q;
  logic [23:0]     dvd_q;
  logic [22:0]     rem_q;
  logic [22:0]     quo_q;

  logic        wr;
  logic [22:0] f_in, f_sat;
  logic [15:0] lv_sat;
  logic [30:0] peak_prod;
  logic [23:0] t;
  logic        ge;
  logic [22:0] rem_d;

  assign cfg_ready_o = ~busy_q;
  assign busy_o      = busy_q;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    f_in = cfg_data_i[22:0];
    if (f_in == '0) begin
      f_sat = 23'd1;
    end else if (f_in > mwo_pkg::FREQ_MAX) begin
      f_sat = mwo_pkg::FREQ_MAX;
    end else begin
      f_sat = f_in;
    end
    lv_sat    = (cfg_data_i[15:0] > mwo_pkg::LEVEL_FULL) ? mwo_pkg::LEVEL_FULL
                                                          : cfg_data_i[15:0];
    peak_prod = {15'b0, lv_sat} * {16'b0, mwo_pkg::AMP_MAX};
    // period = rate / freq, one quotient bit per cycle
    t     = {rem_q, dvd_q[23]};
    ge    = (t >= {1'b0, freq_q});
    rem_d = ge ? 23'(t - {1'b0, freq_q}) : t[22:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= mwo_pkg::SHAPE_SINE;
      freq_q   <= mwo_pkg::FREQ_RESET;
      period_q <= mwo_pkg::PERIOD_RESET;
      peak_q   <= mwo_pkg::PEAK_RESET;
      busy_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == 5'(DivSteps - 1)) begin
        busy_q   <= 1'b0;
        period_q <= {quo_q, ge};
      end
    end else if (wr) begin
      case (cfg_index_i)
        mwo_pkg::REG_SHAPE: shape_q <= mwo_pkg::shape_e'(cfg_data_i[1:0]);
        mwo_pkg::REG_FREQ: begin
          freq_q <= f_sat;
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
        mwo_pkg::REG_LEVEL: peak_q <= peak_prod[29:15];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
      quo_q <= {quo_q[21:0], ge};
    end else begin
      dvd_q <= mwo_pkg::RATE_SCALED;
      rem_q <= '0;
      quo_q <= '0;
    end
  end

  assign cfg_o.shape  = shape_q;
  assign cfg_o.freq   = freq_q;
  assign cfg_o.period = period_q;
  assign cfg_o.peak   = peak_q;

endmodule

[rtl/mwo_back.sv]
module mwo_back #(
  parameter int SineTableDepth = mwo_pkg::SINE_TABLE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mwo_pkg::cfg_t                      cfg_i,
  input  logic                               item_valid_i,
  input  mwo_pkg::item_t                     item_i,
  output logic                               item_pop_o,
  input  logic                               res_ready_i,
  output logic                               res_push_o,
  output logic signed [mwo_pkg::SAMPLE_W-1:0] res_o
);

  localparam int DvdW  = 54;
  localparam int RemW  = 24;
  localparam int QuoW  = 16;
  localparam int NumW  = RemW + QuoW;
  localparam int AddrW = $clog2(SineTableDepth + 1);
  localparam logic [16:0] MulD = 17'(4 * SineTableDepth);
  localparam logic [16:0] Quad1 = 17'(SineTableDepth);
  localparam logic [16:0] Quad2 = 17'(2 * SineTableDepth);
  localparam logic [16:0] Quad3 = 17'(3 * SineTableDepth);

  typedef logic [14:0] rom_t [SineTableDepth + 1];

  function automatic longint mul_q30(longint a, longint b);
    return (a * b) / mwo_pkg::Q30_ONE;
  endfunction

  function automatic rom_t build_rom();
    rom_t   r;
    longint t, t2, p, v;
    for (int i = 0; i <= SineTableDepth; i++) begin
      t  = (longint'(i) * mwo_pkg::Q30_ONE) / SineTableDepth;
      t2 = mul_q30(t, t);
      p  = mwo_pkg::SIN_C3 + mul_q30(mwo_pkg::SIN_C4, t2);
      p  = mwo_pkg::SIN_C2 + mul_q30(p, t2);
      p  = mwo_pkg::SIN_C1 + mul_q30(p, t2);
      p  = mwo_pkg::SIN_C0 + mul_q30(p, t2);
      p  = mul_q30(p, t);
      if (p < 0) p = 0;
      v = (p * 32767 + (mwo_pkg::Q30_ONE / 2)) / mwo_pkg::Q30_ONE;
      if (v > 32767) v = 32767;
      r[i] = 15'(v);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic adv;
  assign adv        = res_ready_i;
  assign item_pop_o = adv & item_valid_i;

  // remainder pipeline: index mod period, or phase product mod rate
  logic                r_v   [DvdW+1];
  mwo_pkg::shape_e     r_sh  [DvdW+1];
  logic [DvdW-1:0]     r_dvd [DvdW+1];
  logic [RemW-1:0]     r_rem [DvdW+1];
  logic [DvdW-1:0]     phase_prod;

  assign phase_prod = {23'b0, item_i.idx} * {31'b0, cfg_i.freq};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v[0] <= 1'b0;
    end else if (adv) begin
      r_v[0] <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_sh[0]  <= item_i.shape;
      r_dvd[0] <= (item_i.shape == mwo_pkg::SHAPE_SINE) ? phase_prod
                                                        : DvdW'(item_i.idx);
      r_rem[0] <= '0;
    end
  end

  for (genvar j = 1; j <= DvdW; j++) begin : g_rem
    logic [RemW:0]   t;
    logic [RemW-1:0] dv;
    logic            ge;

    always_comb begin
      dv = (r_sh[j-1] == mwo_pkg::SHAPE_SINE) ? mwo_pkg::RATE_SCALED : cfg_i.period;
      t  = {r_rem[j-1], r_dvd[j-1][DvdW-1]};
      ge = (t >= {1'b0, dv});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_v[j] <= 1'b0;
      end else if (adv) begin
        r_v[j] <= r_v[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_sh[j]  <= r_sh[j-1];
        r_dvd[j] <= r_dvd[j-1] << 1;
        r_rem[j] <= ge ? RemW'(t - {1'b0, dv}) : t[RemW-1:0];
      end
    end
  end

  // operand set-up for the scaling division
  logic            a_v, a_neg;
  mwo_pkg::shape_e a_sh;
  logic [RemW-1:0] a_mag;
  logic [16:0]     a_mul;
  logic signed [mwo_pkg::SAMPLE_W-1:0] a_res;

  logic [RemW-1:0] c, per;
  logic [26:0]     x;
  logic [RemW-1:0] mag_d;
  logic [16:0]     mul_d;
  logic            neg_d;
  logic signed [mwo_pkg::SAMPLE_W-1:0] res_d, peak_s;

  always_comb begin
    c      = r_rem[DvdW];
    per    = cfg_i.period;
    peak_s = $signed({1'b0, cfg_i.peak});
    x      = '0;
    mag_d  = '0;
    mul_d  = '0;
    neg_d  = 1'b0;
    res_d  = '0;
    case (r_sh[DvdW])
      mwo_pkg::SHAPE_SINE: begin
        mag_d = c;
        mul_d = MulD;
      end
      mwo_pkg::SHAPE_SQUARE: begin
        res_d = (c < (per >> 1)) ? peak_s : -peak_s;
      end
      mwo_pkg::SHAPE_SAW: begin
        x = {2'b0, c, 1'b0} - {3'b0, per};
      end
      default: begin
        if ({c, 1'b0} < {1'b0, per}) begin
          x = {1'b0, c, 2'b0} - {3'b0, per};
        end else begin
          x = {3'b0, per} + {2'b0, per, 1'b0} - {1'b0, c, 2'b0};
        end
      end
    endcase
    if (r_sh[DvdW] == mwo_pkg::SHAPE_SAW || r_sh[DvdW] == mwo_pkg::SHAPE_TRI) begin
      neg_d = x[26];
      mag_d = x[26] ? RemW'(-x) : RemW'(x);
      mul_d = {2'b0, cfg_i.peak};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= r_v[DvdW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_sh  <= r_sh[DvdW];
      a_mag <= mag_d;
      a_mul <= mul_d;
      a_neg <= neg_d;
      a_res <= res_d;
    end
  end

  // quotient pipeline: numerator is below divisor * 2^16
  logic                 d_v   [QuoW+1];
  mwo_pkg::shape_e      d_sh  [QuoW+1];
  logic                 d_neg [QuoW+1];
  logic signed [mwo_pkg::SAMPLE_W-1:0] d_res [QuoW+1];
  logic [RemW-1:0]      d_rem [QuoW+1];
  logic [QuoW-1:0]      d_low [QuoW+1];
  logic [QuoW-1:0]      d_q   [QuoW+1];
  logic [NumW-1:0]      num;

  assign num = {16'b0, a_mag} * {23'b0, a_mul};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v[0] <= 1'b0;
    end else if (adv) begin
      d_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_sh[0]  <= a_sh;
      d_neg[0] <= a_neg;
      d_res[0] <= a_res;
      d_rem[0] <= num[NumW-1:QuoW];
      d_low[0] <= num[QuoW-1:0];
      d_q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    logic [RemW:0]   t;
    logic [RemW-1:0] dv;
    logic            ge;

    always_comb begin
      dv = (d_sh[k-1] == mwo_pkg::SHAPE_SINE) ? mwo_pkg::RATE_SCALED : cfg_i.period;
      t  = {d_rem[k-1], d_low[k-1][QuoW-1]};
      ge = (t >= {1'b0, dv});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_v[k] <= 1'b0;
      end else if (adv) begin
        d_v[k] <= d_v[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d_sh[k]  <= d_sh[k-1];
        d_neg[k] <= d_neg[k-1];
        d_res[k] <= d_res[k-1];
        d_rem[k] <= ge ? RemW'(t - {1'b0, dv}) : t[RemW-1:0];
        d_low[k] <= d_low[k-1] << 1;
        d_q[k]   <= {d_q[k-1][QuoW-2:0], ge};
      end
    end
  end

  // quadrant decode and finished results for the other shapes
  logic             c_v, c_sine, c_neg;
  logic [AddrW-1:0] c_addr;
  logic signed [mwo_pkg::SAMPLE_W-1:0] c_res;

  logic [16:0]      pos;
  logic [16:0]      kk;
  logic [1:0]       quad;
  logic [AddrW-1:0] addr_d;
  logic signed [mwo_pkg::SAMPLE_W-1:0] qres_d;

  always_comb begin
    pos = {1'b0, d_q[QuoW]};
    if (pos < Quad1) begin
      quad = 2'd0;
      kk   = pos;
    end else if (pos < Quad2) begin
      quad = 2'd1;
      kk   = pos - Quad1;
    end else if (pos < Quad3) begin
      quad = 2'd2;
      kk   = pos - Quad2;
    end else begin
      quad = 2'd3;
      kk   = pos - Quad3;
    end
    addr_d = quad[0] ? AddrW'(AddrW'(SineTableDepth) - AddrW'(kk)) : AddrW'(kk);
    if (d_sh[QuoW] == mwo_pkg::SHAPE_SQUARE) begin
      qres_d = d_res[QuoW];
    end else if (d_neg[QuoW]) begin
      qres_d = -$signed({1'b0, d_q[QuoW][14:0]});
    end else begin
      qres_d = $signed({1'b0, d_q[QuoW][14:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= d_v[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_sine <= (d_sh[QuoW] == mwo_pkg::SHAPE_SINE);
      c_neg  <= quad[1];
      c_addr <= addr_d;
      c_res  <= qres_d;
    end
  end

  // table read
  logic             m_v, m_sine, m_neg;
  logic [14:0]      m_tab;
  logic signed [mwo_pkg::SAMPLE_W-1:0] m_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= c_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tab  <= SineRom[c_addr];
      m_sine <= c_sine;
      m_neg  <= c_neg;
      m_res  <= c_res;
    end
  end

  // peak scaling
  logic        e_v, e_sine, e_neg;
  logic [29:0] e_prod;
  logic signed [mwo_pkg::SAMPLE_W-1:0] e_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= m_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_prod <= {15'b0, cfg_i.peak} * {15'b0, m_tab};
      e_sine <= m_sine;
      e_neg  <= m_neg;
      e_res  <= m_res;
    end
  end

  // divide by 32767: (x + (x >> 15) + 1) >> 15 is exact in this range
  logic [30:0] sum;
  logic [14:0] y;

  always_comb begin
    sum = {1'b0, e_prod} + 31'(e_prod >> 15) + 31'd1;
    y   = sum[29:15];
    if (!e_sine) begin
      res_o = e_res;
    end else if (e_neg) begin
      res_o = -$signed({1'b0, y});
    end else begin
      res_o = $signed({1'b0, y});
    end
  end

  assign res_push_o = adv & e_v;

endmodule

[rtl/multi_waveform_oscillator.sv]
// channel   direction  handshake                  payload
// input     in         push / full                sample_index_i
// result    out        pop / empty                audio_sample_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one sample index per cycle is taken while full is low, then passes the input queue,
// 54-step remainder pipeline, set-up, 16-step quotient pipeline, decode, rom read, scaling.
// a tone_frequency write runs a period division; full and cfg_ready_o show it.
// reset loads sine, 112640 (440 Hz) and full-scale level; the sine table is a constant rom.
// a stalled result stalls the back pipeline; the 4-entry input queue takes items till full.
module multi_waveform_oscillator #(
  parameter int SineTableDepth = mwo_pkg::SINE_TABLE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [mwo_pkg::INDEX_W-1:0]         sample_index_i,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [mwo_pkg::SAMPLE_W-1:0] audio_sample_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mwo_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int ItemW = $bits(mwo_pkg::item_t);

  mwo_pkg::cfg_t  cfg;
  logic           busy;
  mwo_pkg::item_t front_item, back_item;
  logic           inq_push, inq_full, inq_empty, inq_pop;
  logic           outq_push, outq_full;
  logic signed [mwo_pkg::SAMPLE_W-1:0] back_res;
  logic [ItemW-1:0] back_item_bits;

  mwo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .cfg_o       (cfg)
  );

  // front: tag each index with the waveform it is for
  assign full             = inq_full | busy;
  assign inq_push         = push & ~full;
  assign front_item.shape = cfg.shape;
  assign front_item.idx   = sample_index_i;

  mwo_queue #(
    .Width (ItemW),
    .Depth (4)
  ) u_inq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (inq_push),
    .data_i  (front_item),
    .full_o  (inq_full),
    .pop_i   (inq_pop),
    .empty_o (inq_empty),
    .data_o  (back_item_bits)
  );

  assign back_item = mwo_pkg::item_t'(back_item_bits);

  mwo_back #(
    .SineTableDepth (SineTableDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (~inq_empty),
    .item_i       (back_item),
    .item_pop_o   (inq_pop),
    .res_ready_i  (~outq_full),
    .res_push_o   (outq_push),
    .res_o        (back_res)
  );

  mwo_queue #(
    .Width (mwo_pkg::SAMPLE_W),
    .Depth (2)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (outq_push),
    .data_i  (back_res),
    .full_o  (outq_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (audio_sample_o)
  );

  // a period division must hold off new samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && cfg_index_i == mwo_pkg::REG_FREQ |=> full && !cfg_ready_o)
    else $error("input open during period division");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outq_push |-> !outq_full)
    else $error("result transfer into a full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inq_pop |-> !inq_empty)
    else $error("back end took from an empty queue");

endmodule
